### hw/rtl/wpfv_pkg.sv
// Shared types and constants for the waypoint follower.
package wpfv_pkg;

	localparam int QueueDepthDef = 16;
	localparam logic [30:0] ReachResetVal = 31'd32768;
	localparam logic [30:0] SpeedResetVal = 31'd131072;

	localparam logic [1:0] OpPose   = 2'd0;
	localparam logic [1:0] OpPush   = 2'd1;
	localparam logic [1:0] OpTick   = 2'd2;
	localparam logic [1:0] OpUnused = 2'd3;

	localparam logic CfgReach = 1'b0;
	localparam logic CfgSpeed = 1'b1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SQ   = 9'b000000010,
		ST_SQRT = 9'b000000100,
		ST_TEST = 9'b000001000,
		ST_POP  = 9'b000010000,
		ST_MUL  = 9'b000100000,
		ST_DIV  = 9'b001000000,
		ST_NEXT = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

endpackage

### hw/rtl/waypoint_follower_velocity.sv
// Waypoint follower: waypoint queue, distance and speed-limited velocity.
//
// channel   dir  handshake             payload
// s_axis    in   s_axis_tvalid/tready  tdata: pos_x,pos_y,pos_z,quat_x..quat_w; tuser: op
// m_axis    out  m_axis_tvalid/tready  tdata: goal_x..goal_qw,vel_x..vel_z,waiting_count
// cfg       in   cfg_valid/cfg_ready   cfg_index (0 reach_threshold, 1 max_speed), cfg_data
//
// A push also pops the head when it starts navigation. A tick runs one shared
// arithmetic unit: squares of the three axes, 34 square-root steps, a test, then
// per axis one product, 32 restoring-divide steps and a store; when a waypoint is
// reached and the next one popped, squares, root and test run again for it.
// Not ready while busy or while a result waits on m_axis. Reset clears control
// state and registers (reach and speed take defaults), but not the queue memory.
module waypoint_follower_velocity #(
	parameter int QUEUE_DEPTH = wpfv_pkg::QueueDepthDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [159:0] s_axis_tdata,  // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w
	input  logic [1:0]   s_axis_tuser,  // op
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [263:0] m_axis_tdata,  // goal_x,y,z, goal_qx,qy,qz,qw, vel_x,y,z, waiting_count
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [30:0]  cfg_data
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [30:0] reach_q, speed_q;
	logic [31:0] here_x_q, here_y_q, here_z_q;
	logic [31:0] tgt_x_q, tgt_y_q, tgt_z_q;
	logic [63:0] tgt_o_q;
	logic        pose_q, active_q;
	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] fill_q;

	logic [159:0] mem_q [QUEUE_DEPTH];

	wpfv_pkg::state_t st_q;
	logic [5:0]   cnt_q;
	logic [1:0]   ax_q;
	logic [67:0]  sum_q;     // dx^2+dy^2+dz^2
	logic [33:0]  root_q;
	logic [69:0]  rem_q;     // sqrt remainder
	logic [67:0]  num_q;     // low word of |d|*s, shifted out during divide
	logic [33:0]  drem_q;
	logic [31:0]  quo_q;
	logic [31:0]  vel_q [3];
	logic [263:0] out_q;
	logic         ovalid_q;

	logic [1:0]  op;
	logic [32:0] d_sel;
	logic [32:0] d_abs;
	logic [33:0] distance;
	logic [30:0] spd;
	logic [65:0] sq;
	logic [63:0] prod;
	logic        popped_q;

	assign op = s_axis_tuser;
	assign cfg_ready = 1'b1;
	assign s_axis_tready = (st_q == wpfv_pkg::ST_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = out_q;
	assign distance = root_q;
	assign spd = (distance < {3'b0, speed_q}) ? distance[30:0] : speed_q;

	always_comb begin
		case (ax_q)
			2'd0:    d_sel = {tgt_x_q[31], tgt_x_q} - {here_x_q[31], here_x_q};
			2'd1:    d_sel = {tgt_y_q[31], tgt_y_q} - {here_y_q[31], here_y_q};
			default: d_sel = {tgt_z_q[31], tgt_z_q} - {here_z_q[31], here_z_q};
		endcase
		d_abs = d_sel[32] ? (33'd0 - d_sel) : d_sel;
	end

	assign sq = d_abs * d_abs;
	assign prod = d_abs * spd;

	// sqrt trial: remainder vs (4*root+1) at the current bit pair
	logic [69:0] rem_sh;
	logic [69:0] trial;
	assign rem_sh = {rem_q[67:0], sum_q[67:66]};
	assign trial = {34'd0, root_q, 2'b01};

	logic [34:0] dsh;
	assign dsh = {drem_q, num_q[67]};

	logic [PW-1:0] head_nx, tail_nx;
	assign head_nx = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	logic s_acc, full;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign full = (fill_q == CW'(QUEUE_DEPTH));

	// memory write/read in a clocked block
	logic [159:0] rd_q;
	always_ff @(posedge clk) begin
		if (s_acc && op == wpfv_pkg::OpPush && !full)
			mem_q[tail_q] <= s_axis_tdata;
		rd_q <= mem_q[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= wpfv_pkg::ReachResetVal;
			speed_q <= wpfv_pkg::SpeedResetVal;
			here_x_q <= '0; here_y_q <= '0; here_z_q <= '0;
			tgt_x_q <= '0; tgt_y_q <= '0; tgt_z_q <= '0; tgt_o_q <= '0;
			pose_q <= 1'b0; active_q <= 1'b0;
			head_q <= '0; tail_q <= '0; fill_q <= '0;
			st_q <= wpfv_pkg::ST_IDLE;
			cnt_q <= '0; ax_q <= '0; popped_q <= 1'b0;
			sum_q <= '0; root_q <= '0; rem_q <= '0; num_q <= '0;
			drem_q <= '0; quo_q <= '0; out_q <= '0; ovalid_q <= 1'b0;
			vel_q[0] <= '0; vel_q[1] <= '0; vel_q[2] <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == wpfv_pkg::CfgReach) reach_q <= cfg_data;
				else speed_q <= cfg_data;
			end
			if (ovalid_q && m_axis_tready)
				ovalid_q <= 1'b0;
			case (st_q)
				wpfv_pkg::ST_IDLE: begin
					if (s_acc) begin
						case (op)
							wpfv_pkg::OpPose: begin
								here_x_q <= s_axis_tdata[31:0];
								here_y_q <= s_axis_tdata[63:32];
								here_z_q <= s_axis_tdata[95:64];
								pose_q <= 1'b1;
							end
							wpfv_pkg::OpPush: begin
								if (!full) begin
									tail_q <= tail_nx;
									fill_q <= fill_q + 1'b1;
								end
								// start: pop head after write lands
								if (!active_q && pose_q && (!full || fill_q != '0)) begin
									active_q <= 1'b1;
									st_q <= wpfv_pkg::ST_POP;
									popped_q <= 1'b0;
									cnt_q <= 6'd1;
								end
							end
							wpfv_pkg::OpTick: begin
								if (active_q && pose_q) begin
									st_q <= wpfv_pkg::ST_SQ;
									ax_q <= 2'd0; sum_q <= '0; popped_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				wpfv_pkg::ST_SQ: begin
					sum_q <= sum_q + {2'b0, sq};
					if (ax_q == 2'd2) begin
						st_q <= wpfv_pkg::ST_SQRT;
						cnt_q <= 6'd33; root_q <= '0; rem_q <= '0;
					end
					ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
				end
				wpfv_pkg::ST_SQRT: begin
					if (rem_sh >= trial) begin
						rem_q <= rem_sh - trial;
						root_q <= {root_q[32:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						root_q <= {root_q[32:0], 1'b0};
					end
					sum_q <= {sum_q[65:0], 2'b00};
					if (cnt_q == '0) st_q <= wpfv_pkg::ST_TEST;
					cnt_q <= cnt_q - 1'b1;
				end
				wpfv_pkg::ST_TEST: begin
					ax_q <= 2'd0;
					if (!popped_q && distance < {3'b0, reach_q}) begin
						if (fill_q != '0) begin
							st_q <= wpfv_pkg::ST_POP; cnt_q <= 6'd1; popped_q <= 1'b1;
						end else begin
							active_q <= 1'b0; st_q <= wpfv_pkg::ST_IDLE;
						end
					end else
						st_q <= wpfv_pkg::ST_MUL;
				end
				wpfv_pkg::ST_POP: begin
					// first pass waits for the registered read
					if (cnt_q != '0) cnt_q <= '0;
					else begin
						tgt_x_q <= rd_q[31:0]; tgt_y_q <= rd_q[63:32];
						tgt_z_q <= rd_q[95:64]; tgt_o_q <= rd_q[159:96];
						head_q <= head_nx;
						fill_q <= fill_q - 1'b1;
						if (popped_q) begin
							st_q <= wpfv_pkg::ST_SQ; ax_q <= 2'd0; sum_q <= '0;
						end else st_q <= wpfv_pkg::ST_IDLE;
					end
				end
				wpfv_pkg::ST_MUL: begin
					// quotient < 2^32, so the high word is already below the divisor
					drem_q <= {2'b0, prod[63:32]};
					num_q <= {prod[31:0], 36'd0};
					quo_q <= '0; cnt_q <= 6'd0;
					st_q <= wpfv_pkg::ST_DIV;
				end
				wpfv_pkg::ST_DIV: begin
					if (dsh >= {1'b0, distance}) begin
						drem_q <= 34'(dsh - {1'b0, distance});
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						drem_q <= dsh[33:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					num_q <= {num_q[66:0], 1'b0};
					if (cnt_q == 6'd31) st_q <= wpfv_pkg::ST_NEXT;
					cnt_q <= cnt_q + 1'b1;
				end
				wpfv_pkg::ST_NEXT: begin
					vel_q[ax_q] <= (distance == '0) ? 32'd0 :
						(d_sel[32] ? 32'd0 - quo_q : quo_q);
					if (ax_q == 2'd2) st_q <= wpfv_pkg::ST_OUT;
					else begin
						ax_q <= ax_q + 1'b1; st_q <= wpfv_pkg::ST_MUL;
					end
				end
				wpfv_pkg::ST_OUT: begin
					out_q <= {3'b0, 5'(fill_q), vel_q[2], vel_q[1], vel_q[0],
						tgt_o_q, tgt_z_q, tgt_y_q, tgt_x_q};
					ovalid_q <= 1'b1;
					st_q <= wpfv_pkg::ST_IDLE;
				end
				default: st_q <= wpfv_pkg::ST_IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(QUEUE_DEPTH)) else $error("fill overflow");
	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != wpfv_pkg::ST_IDLE |-> !s_axis_tready) else $error("ready while busy");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(st_q) == wpfv_pkg::ST_OUT) else $error("stray result");
	a_result_active: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> active_q && pose_q) else $error("result while inactive");

endmodule
